FILE: design/rpdc_pkg.sv
package rpdc_pkg;

    localparam int unsigned MAX_PACKET_LEN = 64;
    localparam int unsigned MIN_PACKET_LEN = 5;

    localparam logic [7:0] START_MARK = 8'h23;
    localparam logic [7:0] CRC_POLY   = 8'h8C;

    localparam logic CFG_OWN_ID       = 1'b0;
    localparam logic CFG_CONFIRM_CODE = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_ID,
        PH_CMD,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_ID_ERR    = 3'd2,
        ST_NOT_CONF  = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_TRUNC     = 3'd5,
        ST_NO_START  = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } rx_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  packet_id;
        logic [7:0]  packet_command;
        logic [31:0] packet_param;
        logic [7:0]  packet_length;
    } verdict_t;

    // CRC-8/Maxim, reflected, one byte per call
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] d_in);
        logic [7:0] crc;
        logic [7:0] d;
        crc = crc_in;
        d   = d_in;
        for (int k = 0; k < 8; k++) begin
            if (crc[0] ^ d[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

FILE: design/reply_packet_deframer_checker_top.sv
// Reply packet deframer and checker.
// A verdict is registered and appears on the m_ side in the cycle after the beat that causes it is accepted.
// Throughput: one byte per cycle while no held verdict stalls s_ready; the per-byte
// CRC and field update sit between the state registers and the single verdict register.
// Reset (aresetn low, synchronous): hunt for start mark, packet state and
// registers cleared, no verdict pending.
module reply_packet_deframer_checker_top
    import rpdc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,

    input  logic     cfg_we,
    input  logic     cfg_addr,
    input  logic [7:0] cfg_wdata,

    input  logic     s_valid,
    output logic     s_ready,
    input  rx_beat_t s_data,

    output logic     m_valid,
    input  logic     m_ready,
    output verdict_t m_data
);

    logic [7:0]  own_id_reg;
    logic [7:0]  confirm_code_reg;

    phase_t      phase_reg, phase_next, phase_step;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [7:0]  decl_len_reg, decl_len_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [7:0]  held_cmd_reg, held_cmd_next;
    logic [31:0] held_param_reg, held_param_next;
    logic        verdict_given_reg, verdict_given_next;

    logic        m_valid_reg;
    verdict_t    m_data_reg;

    logic        accept;
    logic        pkt_verdict;
    logic        verdict;
    status_t     pkt_status;
    verdict_t    result;
    logic [7:0]  crc_fed;
    logic        len_bad;
    logic        body_last;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign crc_fed   = crc8_feed(crc_reg, s_data.rx_byte);
    assign len_bad   = (s_data.rx_byte < 8'(MIN_PACKET_LEN))
                    || (s_data.rx_byte > 8'(MAX_PACKET_LEN));
    assign body_last = ({1'b0, byte_index_reg} + 9'd1) >= {1'b0, decl_len_reg};

    // next-state logic
    always_comb begin
        phase_step = phase_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (s_data.rx_byte == START_MARK) begin
                    phase_step = PH_LEN;
                end
            end
            PH_LEN: begin
                if (!len_bad) begin
                    phase_step = PH_ID;
                end
            end
            PH_ID:   phase_step = PH_CMD;
            PH_CMD:  phase_step = PH_BODY;
            PH_BODY: phase_step = PH_BODY;
            default: phase_step = PH_HUNT;
        endcase

        if (s_data.burst_end) begin
            phase_next = PH_HUNT;
        end else if (verdict_given_reg) begin
            phase_next = phase_reg;
        end else begin
            phase_next = phase_step;
        end
    end

    // datapath and verdict
    always_comb begin
        byte_index_next    = byte_index_reg;
        decl_len_next      = decl_len_reg;
        crc_next           = crc_reg;
        held_id_next       = held_id_reg;
        held_cmd_next      = held_cmd_reg;
        held_param_next    = held_param_reg;
        verdict_given_next = verdict_given_reg;
        pkt_verdict        = 1'b0;
        pkt_status         = ST_OK;

        if (!verdict_given_reg) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (s_data.rx_byte == START_MARK) begin
                        crc_next        = crc8_feed(8'h00, START_MARK);
                        byte_index_next = 8'd1;
                    end
                end
                PH_LEN: begin
                    decl_len_next   = s_data.rx_byte;
                    crc_next        = crc_fed;
                    byte_index_next = 8'd2;
                    if (len_bad) begin
                        pkt_verdict = 1'b1;
                        pkt_status  = ST_BAD_LEN;
                    end
                end
                PH_ID: begin
                    held_id_next    = s_data.rx_byte;
                    crc_next        = crc_fed;
                    byte_index_next = 8'd3;
                end
                PH_CMD: begin
                    held_cmd_next   = s_data.rx_byte;
                    crc_next        = crc_fed;
                    byte_index_next = 8'd4;
                end
                PH_BODY: begin
                    if (body_last) begin
                        pkt_verdict = 1'b1;
                        if (s_data.rx_byte != crc_reg) begin
                            pkt_status = ST_CRC_ERR;
                        end else if (held_id_reg != own_id_reg) begin
                            pkt_status = ST_ID_ERR;
                        end else if (held_cmd_reg != confirm_code_reg) begin
                            pkt_status = ST_NOT_CONF;
                        end else begin
                            pkt_status = ST_OK;
                        end
                    end else begin
                        // first four payload bytes fill the parameter, LSB first
                        if (byte_index_reg[7:2] == 6'd1) begin
                            case (byte_index_reg[1:0])
                                2'd0:    held_param_next[7:0]   = s_data.rx_byte;
                                2'd1:    held_param_next[15:8]  = s_data.rx_byte;
                                2'd2:    held_param_next[23:16] = s_data.rx_byte;
                                default: held_param_next[31:24] = s_data.rx_byte;
                            endcase
                        end
                        crc_next        = crc_fed;
                        byte_index_next = byte_index_reg + 8'd1;
                    end
                end
                default: ;
            endcase
        end

        verdict = !verdict_given_reg && (pkt_verdict || s_data.burst_end);

        result.packet_id      = held_id_next;
        result.packet_command = held_cmd_next;
        result.packet_param   = held_param_next;
        result.packet_length  = decl_len_next;
        if (pkt_verdict) begin
            result.status = pkt_status;
        end else if (phase_step == PH_HUNT) begin
            result.status = ST_NO_START;
        end else begin
            result.status = ST_TRUNC;
        end

        if (verdict) begin
            verdict_given_next = 1'b1;
        end

        // burst end drops all packet state
        if (s_data.burst_end) begin
            byte_index_next    = 8'd0;
            decl_len_next      = 8'd0;
            crc_next           = 8'd0;
            held_id_next       = 8'd0;
            held_cmd_next      = 8'd0;
            held_param_next    = 32'd0;
            verdict_given_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg       <= 8'd0;
            confirm_code_reg <= 8'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_OWN_ID:       own_id_reg       <= cfg_wdata;
                CFG_CONFIRM_CODE: confirm_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            byte_index_reg    <= 8'd0;
            decl_len_reg      <= 8'd0;
            crc_reg           <= 8'd0;
            held_id_reg       <= 8'd0;
            held_cmd_reg      <= 8'd0;
            held_param_reg    <= 32'd0;
            verdict_given_reg <= 1'b0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            byte_index_reg    <= byte_index_next;
            decl_len_reg      <= decl_len_next;
            crc_reg           <= crc_next;
            held_id_reg       <= held_id_next;
            held_cmd_reg      <= held_cmd_next;
            held_param_reg    <= held_param_next;
            verdict_given_reg <= verdict_given_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && verdict) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && verdict) begin
            m_data_reg <= result;
        end
    end

endmodule

FILE: tb/reply_packet_deframer_checker_top_tb.sv
module reply_packet_deframer_checker_top_tb;
    import rpdc_pkg::*;

    // Predicts one verdict per burst and holds the verdicts still to come
    class verdict_scoreboard;
        logic [7:0]  own_id;
        logic [7:0]  confirm_code;
        phase_t      phase;
        logic [7:0]  byte_idx;
        logic [7:0]  decl_len;
        logic [7:0]  crc;
        logic [7:0]  held_id;
        logic [7:0]  held_cmd;
        logic [31:0] held_param;
        bit          verdict_done;
        verdict_t    verdict_q[$];
        int          failures;
        int          compared;
        int          status_count[8];

        function new();
            own_id       = 8'h00;
            confirm_code = 8'h00;
            failures     = 0;
            compared     = 0;
            foreach (status_count[i]) status_count[i] = 0;
            clear_packet();
        endfunction

        static function logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] d);
            logic [7:0] r;
            logic       fb;
            r = c;
            for (int k = 0; k < 8; k++) begin
                fb = r[0] ^ d[k];
                r  = {1'b0, r[7:1]} ^ (fb ? CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function void clear_packet();
            phase        = PH_HUNT;
            byte_idx     = 8'd0;
            decl_len     = 8'd0;
            crc          = 8'h00;
            held_id      = 8'h00;
            held_cmd     = 8'h00;
            held_param   = 32'h0;
            verdict_done = 1'b0;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        // Returns 1 when the beat is consumed, 0 when it falls after a verdict
        function bit note_beat(input logic [7:0] b, input logic last);
            bit       emit;
            status_t  st;
            verdict_t v;
            int       pos;
            if (verdict_done) begin
                if (last) clear_packet();
                return 1'b0;
            end
            emit = 1'b0;
            st   = ST_OK;
            case (phase)
                PH_HUNT: begin
                    if (b == START_MARK) begin
                        crc      = crc_byte(8'h00, b);
                        byte_idx = 8'd1;
                        phase    = PH_LEN;
                    end
                end
                PH_LEN: begin
                    decl_len = b;
                    crc      = crc_byte(crc, b);
                    byte_idx = 8'd2;
                    if (b < MIN_PACKET_LEN || b > MAX_PACKET_LEN) begin
                        emit = 1'b1;
                        st   = ST_BAD_LEN;
                    end else begin
                        phase = PH_ID;
                    end
                end
                PH_ID: begin
                    held_id  = b;
                    crc      = crc_byte(crc, b);
                    byte_idx = 8'd3;
                    phase    = PH_CMD;
                end
                PH_CMD: begin
                    held_cmd = b;
                    crc      = crc_byte(crc, b);
                    byte_idx = 8'd4;
                    phase    = PH_BODY;
                end
                default: begin
                    if (int'(byte_idx) + 1 >= int'(decl_len)) begin
                        // checksum byte: crc first, then id, then command
                        emit = 1'b1;
                        if (b != crc)                     st = ST_CRC_ERR;
                        else if (held_id != own_id)       st = ST_ID_ERR;
                        else if (held_cmd != confirm_code) st = ST_NOT_CONF;
                        else                              st = ST_OK;
                    end else begin
                        pos = int'(byte_idx) - 4;
                        if (pos >= 0 && pos < 4) held_param = held_param | (32'(b) << (8 * pos));
                        crc      = crc_byte(crc, b);
                        byte_idx = byte_idx + 8'd1;
                    end
                end
            endcase
            if (!emit && last) begin
                emit = 1'b1;
                st   = (phase == PH_HUNT) ? ST_NO_START : ST_TRUNC;
            end
            if (emit) begin
                v.status         = st;
                v.packet_id      = held_id;
                v.packet_command = held_cmd;
                v.packet_param   = held_param;
                v.packet_length  = decl_len;
                verdict_q.push_back(v);
                if (last) clear_packet();
                else verdict_done = 1'b1;
            end
            return 1'b1;
        endfunction

        function void check_verdict(input verdict_t got);
            verdict_t want;
            if (verdict_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: verdict with none pending: st=%0d id=%h cmd=%h prm=%h len=%h",
                             got.status, got.packet_id, got.packet_command, got.packet_param,
                             got.packet_length);
                return;
            end
            want = verdict_q.pop_front();
            compared++;
            status_count[want.status]++;
            if (got.status !== want.status || got.packet_id !== want.packet_id ||
                got.packet_command !== want.packet_command ||
                got.packet_param !== want.packet_param ||
                got.packet_length !== want.packet_length) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: verdict %0d mismatch", compared);
                    $display("  expected st=%0d id=%h cmd=%h prm=%h len=%h", want.status,
                             want.packet_id, want.packet_command, want.packet_param,
                             want.packet_length);
                    $display("  actual   st=%0d id=%h cmd=%h prm=%h len=%h", got.status,
                             got.packet_id, got.packet_command, got.packet_param,
                             got.packet_length);
                end
            end
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_addr  = CFG_OWN_ID;
    logic [7:0] cfg_wdata = 8'h00;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    rx_beat_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    verdict_t   m_data;

    verdict_scoreboard sb = new();

    int         src_idle   = 11;
    int         dst_idle   = 66;
    int         hold_left  = 0;
    int         beats_sent = 0;
    int         beats_used = 0;
    int         bursts     = 0;
    logic [7:0] cfg_own    = 8'h00;
    logic [7:0] cfg_conf   = 8'h00;
    logic [7:0] burst_q[$];

    reply_packet_deframer_checker_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("ERROR: run timed out");
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold-off when requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= dst_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_verdict(m_data);
    end

    function automatic logic [7:0] rand_not_mark();
        logic [7:0] b;
        do b = 8'($urandom); while (b == START_MARK);
        return b;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return MAX_PACKET_LEN;
        if (r < 12) return $urandom_range(13, MAX_PACKET_LEN - 1);
        return $urandom_range(MIN_PACKET_LEN, 12);
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{rx_byte: b, burst_end: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        if (sb.note_beat(b, last)) beats_used++;
        @(negedge aclk);
    endtask

    task automatic send_burst();
        for (int i = 0; i < burst_q.size(); i++) send_beat(burst_q[i], i == burst_q.size() - 1);
        burst_q.delete();
        bursts++;
    endtask

    // Whole packet of len bytes: mark, length, id, command, payload, checksum
    task automatic push_packet(input int len, input logic [7:0] id, input logic [7:0] cmd,
                               input logic [7:0] crc_flip);
        logic [7:0] c;
        logic [7:0] b;
        c = 8'h00;
        for (int i = 0; i < len - 1; i++) begin
            case (i)
                0:       b = START_MARK;
                1:       b = 8'(len);
                2:       b = id;
                3:       b = cmd;
                default: b = 8'($urandom);
            endcase
            burst_q.push_back(b);
            c = verdict_scoreboard::crc_byte(c, b);
        end
        burst_q.push_back(c ^ crc_flip);
    endtask

    task automatic random_burst();
        int         r;
        int         pre;
        int         len;
        int         cut;
        logic [7:0] id;
        logic [7:0] cmd;
        logic [7:0] flip;
        r   = $urandom_range(0, 99);
        pre = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        if (r >= 84) begin
            // bursts with no start mark, or raw noise that may hold one
            repeat ($urandom_range(1, 8))
                burst_q.push_back((r < 90) ? rand_not_mark() : 8'($urandom));
        end else begin
            repeat (pre) burst_q.push_back(rand_not_mark());
            if (r >= 78) begin
                burst_q.push_back(START_MARK);
                burst_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, MIN_PACKET_LEN - 1))
                                                       : 8'($urandom_range(MAX_PACKET_LEN + 1, 255)));
            end else begin
                len  = pick_len();
                id   = cfg_own;
                cmd  = cfg_conf;
                flip = 8'h00;
                if (r >= 50 && r < 58) begin
                    flip = 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 1)) id = 8'($urandom);
                end else if (r >= 58 && r < 64) begin
                    id = cfg_own ^ 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 1)) cmd = 8'($urandom);
                end else if (r >= 64 && r < 70) begin
                    cmd = cfg_conf ^ 8'($urandom_range(1, 255));
                end
                push_packet(len, id, cmd, flip);
                if (r >= 70) begin
                    // cut the packet short before its checksum
                    cut = $urandom_range(1, len - 1);
                    while (burst_q.size() > pre + cut) void'(burst_q.pop_back());
                end
            end
            if ((r < 70 || r >= 78) && $urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) burst_q.push_back(8'($urandom));
        end
        send_burst();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_regs(input logic [7:0] id_val, input logic [7:0] conf_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_OWN_ID;
        cfg_wdata <= id_val;
        @(negedge aclk);
        cfg_addr  <= CFG_CONFIRM_CODE;
        cfg_wdata <= conf_val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.own_id       = id_val;
        sb.confirm_code = conf_val;
        cfg_own         = id_val;
        cfg_conf        = conf_val;
    endtask

    initial begin
        int target;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed bursts under the reset register values
        burst_q.push_back(8'h00);
        send_burst();
        burst_q.push_back(8'hFF);
        burst_q.push_back(START_MARK);
        send_burst();
        burst_q.push_back(START_MARK);
        burst_q.push_back(8'(MIN_PACKET_LEN - 1));
        send_burst();
        burst_q.push_back(START_MARK);
        burst_q.push_back(8'(MAX_PACKET_LEN + 1));
        burst_q.push_back(8'hAA);
        burst_q.push_back(START_MARK);
        send_burst();
        push_packet(MIN_PACKET_LEN, 8'h00, 8'h00, 8'h00);
        send_burst();
        push_packet(MIN_PACKET_LEN, 8'h00, 8'h00, 8'hFF);
        burst_q.push_back(8'h5A);
        send_burst();
        burst_q.push_back(START_MARK);
        burst_q.push_back(8'd9);
        burst_q.push_back(8'h12);
        burst_q.push_back(8'h34);
        send_burst();
        drain();

        for (int ch = 0; ch < 6; ch++) begin
            if (ch < 2) begin
                src_idle = 11;
                dst_idle = 66;
            end else if (ch < 4) begin
                src_idle = 66;
                dst_idle = 11;
            end else begin
                src_idle = 0;
                dst_idle = 0;
            end
            case (ch)
                0:       set_regs(8'hFF, 8'h00);
                1:       set_regs(8'h00, 8'hFF);
                5:       set_regs(8'hFF, 8'hFF);
                default: set_regs(8'($urandom), 8'($urandom));
            endcase
            if (ch == 4) begin
                // hold the receiver off so the block backs up into its input
                @(posedge aclk);
                hold_left = 400;
                @(negedge aclk);
            end
            target = beats_used + 255;
            while (beats_used < target) random_burst();
            drain();
        end

        repeat (8) @(negedge aclk);
        if (sb.pending() != 0) begin
            sb.failures++;
            $display("ERROR: %0d verdicts never arrived", sb.pending());
        end
        $display("Sent %0d beats in %0d bursts over six register settings, %0d verdicts compared",
                 beats_sent, bursts, sb.compared);
        $display("Verdicts: ok %0d, crc %0d, id %0d, command %0d, length %0d, truncated %0d, no mark %0d",
                 sb.status_count[ST_OK], sb.status_count[ST_CRC_ERR], sb.status_count[ST_ID_ERR],
                 sb.status_count[ST_NOT_CONF], sb.status_count[ST_BAD_LEN],
                 sb.status_count[ST_TRUNC], sb.status_count[ST_NO_START]);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
